// File: src/ppns_pkg.sv
`timescale 1ns / 1ps
package ppns_pkg;

  localparam int unsigned DefMaxPoints = 65536;
  localparam int unsigned CoordW = 32;
  localparam int unsigned IdxW = 16;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned SqrtSteps = 32;

  typedef enum logic [1:0] {
    REG_QUERY_X = 2'd0,
    REG_QUERY_Y = 2'd1,
    REG_QUERY_Z = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_PROD,
    ST_SUM,
    ST_DECIDE,
    ST_DIV,
    ST_LERP_MUL,
    ST_LERP_ADD,
    ST_ERR,
    ST_ERR_SQ,
    ST_CMP,
    ST_SQRT,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_diff;
    logic load_prod;
    logic load_sum;
    logic pick_a;
    logic pick_b;
    logic div_init;
    logic div_step;
    logic lerp_mul;
    logic lerp_add;
    logic load_err;
    logic load_err_sq;
    logic update_best;
    logic store_prev;
    logic sqrt_init;
    logic sqrt_step;
    logic load_out;
    logic clear_poly;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic num_le_zero;
    logic num_ge_den;
    logic better;
    logic has_prev;
    logic first_seg;
    logic full;
    logic last;
  } sts_t;

endpackage

// File: src/point_polyline_nearest_segment.sv
`timescale 1ns / 1ps
// Nearest segment of a streamed 3-D polyline to a query point.
// Write the query point through cfg_we_i / cfg_idx_i / cfg_data_i while the
// block is idle: index 0 is x, 1 is y, 2 is z, all signed Q16.16.
// Vertices enter one item at a time on the vertex channel (valid/ready).
// A vertex with last_vertex set ends the polyline and produces one result
// item on the output channel: distance, segment index, closest point and
// no_segment for polylines with fewer than two vertices.
// An accepted vertex goes through the diff, product, sum and decide states;
// a clamped projection goes on to the error states, else the 31-step restoring
// divider for the projection parameter and the interpolation come first. The
// first vertex of a polyline is only stored. The last vertex adds the
// bit-serial square root and the output load. One vertex is worked on at a time.
// The result sits in an output register; while the receiver stalls, the
// block still takes vertices and only waits if a second result is ready.
// Reset clears the query to zero and starts an empty polyline.
module point_polyline_nearest_segment #(
  parameter int unsigned MaxPoints = ppns_pkg::DefMaxPoints
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [ppns_pkg::CoordW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [ppns_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [ppns_pkg::CoordW-1:0] vertex_y_i,
  input  logic signed [ppns_pkg::CoordW-1:0] vertex_z_i,
  input  logic last_vertex_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [ppns_pkg::CoordW-1:0] min_distance_o,
  output logic [ppns_pkg::IdxW-1:0] segment_index_o,
  output logic signed [ppns_pkg::CoordW-1:0] closest_x_o,
  output logic signed [ppns_pkg::CoordW-1:0] closest_y_o,
  output logic signed [ppns_pkg::CoordW-1:0] closest_z_o,
  output logic no_segment_o
);
  import ppns_pkg::*;

  logic signed [CoordW-1:0] qx_q, qy_q, qz_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
      qz_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_QUERY_X: qx_q <= cfg_data_i;
        REG_QUERY_Y: qy_q <= cfg_data_i;
        REG_QUERY_Z: qz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ppns_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ppns_dp #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i, .rst_ni,
    .query_x_i(qx_q), .query_y_i(qy_q), .query_z_i(qz_q),
    .vertex_x_i, .vertex_y_i, .vertex_z_i, .last_vertex_i,
    .cmd_i(cmd), .sts_o(sts),
    .min_distance_o, .segment_index_o, .closest_x_o, .closest_y_o,
    .closest_z_o, .no_segment_o
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");
  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten");
  a_best_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update_best |-> cmd.store_prev)
    else $error("best updated outside segment close");

endmodule

// File: src/ppns_ctrl.sv
`timescale 1ns / 1ps
module ppns_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ppns_pkg::sts_t sts_i,
  output ppns_pkg::cmd_t cmd_o
);
  import ppns_pkg::*;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (sts_i.full) begin
          state_d = sts_i.last ? ST_SQRT : ST_IDLE;
          cmd_o.sqrt_init = sts_i.last;
          cnt_d = '0;
        end else if (!sts_i.has_prev) begin
          cmd_o.store_prev = 1'b1;
          state_d = sts_i.last ? ST_SQRT : ST_IDLE;
          cmd_o.sqrt_init = sts_i.last;
          cnt_d = '0;
        end else begin
          cmd_o.load_diff = 1'b1;
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.load_prod = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.load_sum = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.num_le_zero) begin
          cmd_o.pick_a = 1'b1;
          state_d = ST_ERR;
        end else if (sts_i.num_ge_den) begin
          cmd_o.pick_b = 1'b1;
          state_d = ST_ERR;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DivSteps - 1)) state_d = ST_LERP_MUL;
      end
      ST_LERP_MUL: begin
        cmd_o.lerp_mul = 1'b1;
        state_d = ST_LERP_ADD;
      end
      ST_LERP_ADD: begin
        cmd_o.lerp_add = 1'b1;
        state_d = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.load_err = 1'b1;
        state_d = ST_ERR_SQ;
      end
      ST_ERR_SQ: begin
        cmd_o.load_err_sq = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.update_best = sts_i.first_seg || sts_i.better;
        cmd_o.store_prev = 1'b1;
        cnt_d = '0;
        cmd_o.sqrt_init = sts_i.last;
        state_d = sts_i.last ? ST_SQRT : ST_IDLE;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SqrtSteps - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        // Wait until the output register is free, then hand over the item.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          cmd_o.clear_poly = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: src/ppns_dp.sv
`timescale 1ns / 1ps
module ppns_dp #(
  parameter int unsigned MaxPoints = ppns_pkg::DefMaxPoints,
  localparam int unsigned CntW = $clog2(MaxPoints + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [ppns_pkg::CoordW-1:0] query_x_i,
  input  logic signed [ppns_pkg::CoordW-1:0] query_y_i,
  input  logic signed [ppns_pkg::CoordW-1:0] query_z_i,
  input  logic signed [ppns_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [ppns_pkg::CoordW-1:0] vertex_y_i,
  input  logic signed [ppns_pkg::CoordW-1:0] vertex_z_i,
  input  logic                         last_vertex_i,
  input  ppns_pkg::cmd_t               cmd_i,
  output ppns_pkg::sts_t               sts_o,
  output logic [ppns_pkg::CoordW-1:0] min_distance_o,
  output logic [ppns_pkg::IdxW-1:0]   segment_index_o,
  output logic signed [ppns_pkg::CoordW-1:0] closest_x_o,
  output logic signed [ppns_pkg::CoordW-1:0] closest_y_o,
  output logic signed [ppns_pkg::CoordW-1:0] closest_z_o,
  output logic                         no_segment_o
);
  import ppns_pkg::*;

  // Three lanes, one per axis.
  logic signed [CoordW-1:0] vtx_q [3];
  logic signed [CoordW-1:0] prev_q [3];
  logic signed [CoordW-1:0] qry [3];
  logic signed [CoordW:0]   d_q [3];
  logic signed [CoordW:0]   w_q [3];
  logic signed [66:0]       pn_q [3];
  logic [65:0]              pd_q [3];
  logic signed [68:0]       num_q;
  logic [67:0]              den_q;
  logic [68:0]              rem_q;
  logic [DivSteps-1:0]      t_q;
  logic [63:0]              off_q [3];
  logic signed [CoordW-1:0] c_q [3];
  logic signed [CoordW:0]   e_q [3];
  logic [65:0]              esq_q [3];
  logic [63:0]              dsq;
  logic last_q;
  logic [CntW-1:0] cnt_q;
  logic [63:0] best_q;
  logic [IdxW-1:0] bidx_q;
  logic signed [CoordW-1:0] bpt_q [3];
  logic [63:0] srem_q, root_q, sbit_q;
  logic [67:0] esum;
  logic [68:0] rem_sh;

  assign qry[0] = query_x_i;
  assign qry[1] = query_y_i;
  assign qry[2] = query_z_i;

  assign esum = {2'b0, esq_q[0]} + {2'b0, esq_q[1]} + {2'b0, esq_q[2]};
  assign dsq = (esum[67:64] != 4'd0) ? '1 : esum[63:0];
  assign rem_sh = {rem_q[67:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      best_q <= '1;
      bidx_q <= '0;
      for (int k = 0; k < 3; k++) begin
        prev_q[k] <= '0;
        bpt_q[k] <= '0;
      end
    end else if (cmd_i.clear_poly) begin
      cnt_q <= '0;
      best_q <= '1;
      bidx_q <= '0;
      for (int k = 0; k < 3; k++) begin
        prev_q[k] <= '0;
        bpt_q[k] <= '0;
      end
    end else begin
      if (cmd_i.update_best) begin
        best_q <= dsq;
        bidx_q <= IdxW'(cnt_q - CntW'(1));
        for (int k = 0; k < 3; k++) bpt_q[k] <= c_q[k];
      end
      if (cmd_i.store_prev) begin
        cnt_q <= cnt_q + CntW'(1);
        for (int k = 0; k < 3; k++) prev_q[k] <= vtx_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vtx_q[0] <= vertex_x_i;
      vtx_q[1] <= vertex_y_i;
      vtx_q[2] <= vertex_z_i;
      last_q <= last_vertex_i;
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.load_diff) begin
        d_q[k] <= (CoordW+1)'(vtx_q[k]) - (CoordW+1)'(prev_q[k]);
        w_q[k] <= (CoordW+1)'(qry[k]) - (CoordW+1)'(prev_q[k]);
      end
      if (cmd_i.load_prod) begin
        pn_q[k] <= 67'(d_q[k] * w_q[k]);
        pd_q[k] <= 66'(d_q[k] * d_q[k]);
      end
      if (cmd_i.pick_a) c_q[k] <= prev_q[k];
      if (cmd_i.pick_b) c_q[k] <= vtx_q[k];
      if (cmd_i.lerp_mul)
        off_q[k] <= 64'(((d_q[k][CoordW] ? -d_q[k] : d_q[k]) & {1'b0, {CoordW{1'b1}}}) * t_q);
      if (cmd_i.lerp_add) begin
        if (d_q[k][CoordW])
          c_q[k] <= prev_q[k] - CoordW'((off_q[k] + 64'h4000_0000) >> 31);
        else
          c_q[k] <= prev_q[k] + CoordW'((off_q[k] + 64'h4000_0000) >> 31);
      end
      if (cmd_i.load_err) e_q[k] <= (CoordW+1)'(c_q[k]) - (CoordW+1)'(qry[k]);
      if (cmd_i.load_err_sq) esq_q[k] <= 66'(e_q[k] * e_q[k]);
    end
    if (cmd_i.load_sum) begin
      num_q <= 69'(pn_q[0]) + 69'(pn_q[1]) + 69'(pn_q[2]);
      den_q <= 68'(pd_q[0]) + 68'(pd_q[1]) + 68'(pd_q[2]);
    end
    if (cmd_i.div_init) begin
      rem_q <= num_q;
      t_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        t_q <= {t_q[DivSteps-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        t_q <= {t_q[DivSteps-2:0], 1'b0};
      end
    end
    if (cmd_i.sqrt_init) begin
      // The closing segment of the polyline may replace the best distance in this very cycle.
      srem_q <= cmd_i.update_best ? dsq : best_q;
      root_q <= '0;
      sbit_q <= 64'h4000_0000_0000_0000;
    end
    if (cmd_i.sqrt_step) begin
      if (srem_q >= root_q + sbit_q) begin
        srem_q <= srem_q - (root_q + sbit_q);
        root_q <= (root_q >> 1) + sbit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    if (cmd_i.load_out) begin
      if (cnt_q < CntW'(2)) begin
        min_distance_o <= '1;
        segment_index_o <= '0;
        closest_x_o <= '0;
        closest_y_o <= '0;
        closest_z_o <= '0;
        no_segment_o <= 1'b1;
      end else begin
        min_distance_o <= root_q[CoordW-1:0];
        segment_index_o <= bidx_q;
        closest_x_o <= bpt_q[0];
        closest_y_o <= bpt_q[1];
        closest_z_o <= bpt_q[2];
        no_segment_o <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o = '0;
    sts_o.num_le_zero = num_q[68] || (num_q == '0);
    sts_o.num_ge_den = num_q >= $signed({1'b0, den_q});
    sts_o.better = dsq < best_q;
    sts_o.has_prev = cnt_q != '0;
    sts_o.first_seg = cnt_q == CntW'(1);
    sts_o.full = cnt_q >= CntW'(MaxPoints);
    sts_o.last = last_q;
  end

endmodule
